[design/assert_macros.svh]
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off while in reset
`define DRQ_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock, off while in reset
`define DRQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/drq_pkg.sv]
// shared types and codes for the dual ticket queue with weighted call
// no dependencies
package drq_pkg;

    localparam int TICKET_W  = 16;
    localparam int OP_W      = 2;
    localparam int KIND_W    = 2;
    localparam int COUNT_W   = 4;
    localparam int M_TDATA_W = 32;
    localparam int M_PAD_W   = M_TDATA_W - (1 + TICKET_W + 1 + 2 * COUNT_W);

    localparam logic [OP_W-1:0] OP_INS_NORMAL = 2'd0;
    localparam logic [OP_W-1:0] OP_INS_PREF   = 2'd1;
    localparam logic [OP_W-1:0] OP_CALL       = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CALLED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_ACK,
        ST_CALL_P,
        ST_EMIT_P,
        ST_CALL_N,
        ST_EMIT_N
    } state_t;

    typedef struct packed {
        logic                push;
        logic                pop;
        logic [TICKET_W-1:0] wdata;
    } ring_cmd_t;

    typedef struct packed {
        logic               empty;
        logic               full;
        logic [COUNT_W-1:0] count;
    } ring_stat_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic                accepted;
        logic [TICKET_W-1:0] ticket_out;
        logic                from_preferential;
        logic [COUNT_W-1:0]  normal_count;
        logic [COUNT_W-1:0]  preferential_count;
        logic                last;
    } result_t;

endpackage

[design/drq_ring.sv]
// one circular ticket queue: synchronous store plus head and tail pointers
// depends on drq_pkg
module drq_ring #(
    parameter int QUEUE_SIZE = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  drq_pkg::ring_cmd_t            cmd,
    output drq_pkg::ring_stat_t           stat,
    output logic [drq_pkg::TICKET_W-1:0]  rd_data
);
    import drq_pkg::*;

    localparam int PTR_W  = (QUEUE_SIZE > 2) ? $clog2(QUEUE_SIZE) : 1;
    localparam int FILL_W = PTR_W + 1;
    localparam logic [PTR_W-1:0]  LAST_SLOT = PTR_W'(QUEUE_SIZE - 1);
    localparam logic [FILL_W-1:0] DEPTH     = FILL_W'(QUEUE_SIZE);

    logic [TICKET_W-1:0] mem [QUEUE_SIZE];
    logic [TICKET_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]    head_reg, head_next, head_inc;
    logic [PTR_W-1:0]    tail_reg, tail_next, tail_inc;
    logic [FILL_W-1:0]   fill;

    always_comb
    begin
        head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
        tail_inc = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
        head_next = cmd.pop  ? head_inc : head_reg;
        tail_next = cmd.push ? tail_inc : tail_reg;
        if (tail_reg >= head_reg)
        begin
            fill = {1'b0, tail_reg} - {1'b0, head_reg};
        end
        else
        begin
            fill = {1'b0, tail_reg} + DEPTH - {1'b0, head_reg};
        end
        stat.empty = (head_reg == tail_reg);
        stat.full  = (tail_inc == head_reg);
        stat.count = COUNT_W'(fill);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // store written at the slot after the tail, read at the slot after the head
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[tail_inc] <= cmd.wdata;
        end
        if (cmd.pop)
        begin
            rd_data_reg <= mem[head_inc];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/drq_ctrl.sv]
// sequencer: input register, insert and call steps, registered result beat
// depends on drq_pkg
module drq_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [drq_pkg::TICKET_W-1:0]    s_axis_tdata,
    input  logic [drq_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [drq_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic [drq_pkg::KIND_W-1:0]      m_axis_tuser,
    output logic                            m_axis_tlast,
    output drq_pkg::ring_cmd_t              norm_cmd,
    output drq_pkg::ring_cmd_t              pref_cmd,
    input  drq_pkg::ring_stat_t             norm_stat,
    input  drq_pkg::ring_stat_t             pref_stat,
    input  logic [drq_pkg::TICKET_W-1:0]    norm_rd,
    input  logic [drq_pkg::TICKET_W-1:0]    pref_rd
);
    import drq_pkg::*;

    state_t              state_reg, state_next;
    logic [OP_W-1:0]     op_reg;
    logic [TICKET_W-1:0] ticket_reg;
    logic                accepted_reg, accepted_next;
    logic                second_reg, second_next;
    logic                m_valid_reg, m_valid_next;
    result_t             res_reg, res;
    logic                out_free, load;

    assign out_free = !m_valid_reg || m_axis_tready;

    // outputs of each step
    always_comb
    begin
        s_axis_tready = 1'b0;
        load          = 1'b0;
        accepted_next = accepted_reg;
        norm_cmd      = '{push: 1'b0, pop: 1'b0, wdata: ticket_reg};
        pref_cmd      = '{push: 1'b0, pop: 1'b0, wdata: ticket_reg};
        res.kind               = KIND_CALLED;
        res.accepted           = 1'b1;
        res.ticket_out         = '0;
        res.from_preferential  = 1'b0;
        res.normal_count       = norm_stat.count;
        res.preferential_count = pref_stat.count;
        res.last               = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_INSERT:
            begin
                if (op_reg == OP_INS_NORMAL)
                begin
                    norm_cmd.push = !norm_stat.full;
                    accepted_next = !norm_stat.full;
                end
                else
                begin
                    pref_cmd.push = !pref_stat.full;
                    accepted_next = !pref_stat.full;
                end
            end
            ST_ACK:
            begin
                load         = out_free;
                res.kind     = KIND_ACK;
                res.accepted = accepted_reg;
            end
            ST_CALL_P:
            begin
                if (!pref_stat.empty)
                begin
                    pref_cmd.pop = 1'b1;
                end
                else if (norm_stat.empty)
                begin
                    load     = out_free;
                    res.kind = KIND_EMPTY;
                end
            end
            ST_EMIT_P:
            begin
                load                  = out_free;
                res.ticket_out        = pref_rd;
                res.from_preferential = 1'b1;
                res.last              = norm_stat.empty;
            end
            ST_CALL_N:
            begin
                norm_cmd.pop = 1'b1;
            end
            ST_EMIT_N:
            begin
                load           = out_free;
                res.ticket_out = norm_rd;
                res.last       = norm_stat.empty || second_reg;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // next step
    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        case (state_reg)
            ST_IDLE:
            begin
                second_next = 1'b0;
                if (s_axis_tvalid)
                begin
                    if ((s_axis_tuser == OP_INS_NORMAL) || (s_axis_tuser == OP_INS_PREF))
                    begin
                        state_next = ST_INSERT;
                    end
                    else
                    begin
                        state_next = ST_CALL_P;
                    end
                end
            end
            ST_INSERT:
            begin
                state_next = ST_ACK;
            end
            ST_ACK:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CALL_P:
            begin
                if (!pref_stat.empty)
                begin
                    state_next = ST_EMIT_P;
                end
                else if (!norm_stat.empty)
                begin
                    state_next = ST_CALL_N;
                end
                else if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_P:
            begin
                if (load)
                begin
                    state_next = res.last ? ST_IDLE : ST_CALL_N;
                end
            end
            ST_CALL_N:
            begin
                state_next = ST_EMIT_N;
            end
            ST_EMIT_N:
            begin
                if (load)
                begin
                    second_next = 1'b1;
                    state_next  = res.last ? ST_IDLE : ST_CALL_N;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            second_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
            accepted_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            second_reg   <= second_next;
            m_valid_reg  <= m_valid_next;
            accepted_reg <= accepted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg     <= s_axis_tuser;
            ticket_reg <= s_axis_tdata;
        end
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tlast  = res_reg.last;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, res_reg.preferential_count,
                            res_reg.normal_count, res_reg.from_preferential,
                            res_reg.ticket_out, res_reg.accepted};

endmodule

[design/dual_ring_queue_weighted_call.sv]
// steps: a result beat is registered once its accepted input beat has passed its steps
// (insert: push then acknowledge; call: store read then beat), each further called
// ticket after another read and beat; a call on two empty queues has no read step
// throughput: one item at a time, ready again once its last beat is registered;
// each result step waits while an earlier result beat is still stalled
// reset: rst_n, asynchronous active low, clears pointers, sequencer and valid; stores kept
module dual_ring_queue_weighted_call #(
    parameter int QUEUE_SIZE = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // input beats
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] ticket
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    // result beats
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [0] accepted, [16:1] ticket_out,
                                        // [17] from_preferential, [21:18] normal_count,
                                        // [25:22] preferential_count, [31:26] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // last beat caused by one input beat
);
    import drq_pkg::*;

    ring_cmd_t           norm_cmd, pref_cmd;
    ring_stat_t          norm_stat, pref_stat;
    logic [TICKET_W-1:0] norm_rd, pref_rd;

    // normal queue: holds up to QUEUE_SIZE-1 tickets, one slot always left free
    drq_ring #(
        .QUEUE_SIZE (QUEUE_SIZE)
    ) u_norm_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (norm_cmd),
        .stat    (norm_stat),
        .rd_data (norm_rd)
    );

    // preferential queue, same organisation
    drq_ring #(
        .QUEUE_SIZE (QUEUE_SIZE)
    ) u_pref_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (pref_cmd),
        .stat    (pref_stat),
        .rd_data (pref_rd)
    );

    // sequencer: a call takes one preferential ticket if there is one, then up to two normal ones;
    // the output register lets an item be taken while its last beat still waits
    drq_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .norm_cmd      (norm_cmd),
        .pref_cmd      (pref_cmd),
        .norm_stat     (norm_stat),
        .pref_stat     (pref_stat),
        .norm_rd       (norm_rd),
        .pref_rd       (pref_rd)
    );

endmodule

[design/drq_checker.sv]
// port-level checks for the dual ticket queue, bound to the top level
// depends on drq_pkg and assert_macros.svh
`include "assert_macros.svh"

module drq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import drq_pkg::*;

    // an acknowledge is always the only beat of its item
    `DRQ_ASSERT_SAME(a_ack_last, clk, rst_n, m_axis_tvalid && (m_axis_tuser == KIND_ACK), m_axis_tlast, "insert acknowledge without tlast")

    // an empty call finds both queues empty and carries no ticket
    `DRQ_ASSERT_SAME(a_empty_beat, clk, rst_n, m_axis_tvalid && (m_axis_tuser == KIND_EMPTY), m_axis_tlast && m_axis_tdata[0] && (m_axis_tdata[25:1] == 25'd0), "malformed empty-call beat")

    // only a called ticket can be marked preferential
    `DRQ_ASSERT_SAME(a_pref_called, clk, rst_n, m_axis_tvalid && m_axis_tdata[17], m_axis_tuser == KIND_CALLED, "preferential flag on a non-call beat")

    // one item at a time: no second beat taken in the cycle after an acceptance
    `DRQ_ASSERT_NEXT(a_one_item, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while an item is in progress")

    // a stalled result beat holds
    `DRQ_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result beat changed")

endmodule

bind dual_ring_queue_weighted_call drq_checker u_drq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
